// ----- design/bvm_pkg.sv -----
// Shared constants, register indexes and interface structs for the battery
// voltage monitor. No dependencies; used by every module of the block.
package bvm_pkg;

  // Window depth and converter resolution
  localparam int unsigned WINDOW   = 16;
  localparam int unsigned ADC_BITS = 10;

  // Field widths
  localparam int unsigned ADC_W   = 10;
  localparam int unsigned SCALE_W = 16;
  localparam int unsigned MV_W    = 18;
  localparam int unsigned PCT_W   = 7;

  // Derived widths
  localparam int unsigned SUM_W  = MV_W + $clog2(WINDOW);
  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned PROD_W = ADC_BITS + SCALE_W;
  localparam int unsigned NUM_W  = MV_W + PCT_W;
  localparam int unsigned STEP_W = $clog2(MV_W + 1);
  localparam int unsigned FRAC_BITS = 8;

  // Stream and config port widths
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 32;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 18;

  localparam logic [MV_W-1:0]  MV_MAX   = {MV_W{1'b1}};
  localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(100);

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MV_PER_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY_MV     = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] REG_FULL_MV      = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_CRITICAL_MV  = CFG_IDX_W'(3);

  // Register reset values
  localparam logic [SCALE_W-1:0] RST_MV_PER_COUNT = SCALE_W'(22373);
  localparam logic [MV_W-1:0]    RST_EMPTY_MV     = MV_W'(30000);
  localparam logic [MV_W-1:0]    RST_FULL_MV      = MV_W'(42000);
  localparam logic [MV_W-1:0]    RST_CRITICAL_MV  = MV_W'(32000);

  typedef struct packed {
    logic [SCALE_W-1:0] mv_per_count_q8;
    logic [MV_W-1:0]    empty_mv;
    logic [MV_W-1:0]    full_mv;
    logic [MV_W-1:0]    critical_mv;
  } bvm_cfg_t;

  // Controller -> datapath
  typedef struct packed {
    logic load_sample;
    logic scale;
    logic update;
    logic div_load_avg;
    logic div_step;
    logic classify;
    logic div_load_pct;
    logic emit;
  } bvm_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic div_done;
    logic in_span;
    logic out_busy;
  } bvm_status_t;

endpackage

// ----- design/bvm_datapath.sv -----
// Datapath of the battery voltage monitor: scaling, sample window, running
// sum, shared restoring divider and output register. Depends on bvm_pkg.
module bvm_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bvm_pkg::bvm_cmd_t             cmd_i,
  output bvm_pkg::bvm_status_t          status_o,
  input  bvm_pkg::bvm_cfg_t             cfg_i,
  input  logic [bvm_pkg::ADC_W-1:0]     adc_sample_i,
  input  logic                          out_ready_i,
  output logic                          out_valid_o,
  output logic [bvm_pkg::MV_W-1:0]      average_mv_o,
  output logic [bvm_pkg::PCT_W-1:0]     charge_percent_o,
  output logic                          unsafe_o,
  output logic                          window_full_o
);
  import bvm_pkg::*;

  logic [ADC_W-1:0]  sample_q;
  logic [MV_W-1:0]   mv_q;
  logic [MV_W-1:0]   window_q [WINDOW];
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [MV_W-1:0]   rem_q, rem_d;
  logic [MV_W-1:0]   quo_q, quo_d;
  logic [MV_W-1:0]   den_q;
  logic [STEP_W-1:0] step_q, step_d;
  logic [MV_W-1:0]   avg_q;
  logic              in_span_q, ge_full_q, unsafe_q;
  logic              out_valid_q;
  logic [MV_W-1:0]   out_avg_q;
  logic [PCT_W-1:0]  out_pct_q;
  logic              out_unsafe_q, out_full_q;

  logic [ADC_BITS-1:0] counts;
  logic [PROD_W-1:0]   prod, prod_sh;
  logic [MV_W-1:0]     mv_d;
  logic                win_full;
  logic [MV_W-1:0]     old_mv;
  logic [MV_W:0]       trial, diff;
  logic                ge;
  logic [NUM_W-1:0]    num;

  // Scale: (counts * q8) >> 8, saturated to the millivolt range
  assign counts  = ADC_BITS'(sample_q);
  assign prod    = PROD_W'(counts) * PROD_W'(cfg_i.mv_per_count_q8);
  assign prod_sh = prod >> FRAC_BITS;
  assign mv_d    = (prod_sh > PROD_W'(MV_MAX)) ? MV_MAX : MV_W'(prod_sh);

  // Until the window has wrapped, the slot being overwritten was never written
  assign win_full = (count_q == CNT_W'(WINDOW));
  assign old_mv   = win_full ? window_q[slot_q] : '0;

  // Restoring divider step
  assign trial = {rem_q, quo_q[MV_W-1]};
  assign ge    = (trial >= {1'b0, den_q});
  assign diff  = trial - {1'b0, den_q};

  assign num = NUM_W'(avg_q - cfg_i.empty_mv) * NUM_W'(PCT_FULL);

  always_comb begin
    slot_d  = slot_q;
    count_d = count_q;
    sum_d   = sum_q;
    if (cmd_i.update) begin
      sum_d   = sum_q - SUM_W'(old_mv) + SUM_W'(mv_q);
      slot_d  = (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
      count_d = win_full ? count_q : count_q + CNT_W'(1);
    end
  end

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    step_d = step_q;
    if (cmd_i.div_load_avg) begin
      rem_d  = MV_W'(sum_q >> MV_W);
      quo_d  = sum_q[MV_W-1:0];
      step_d = STEP_W'(MV_W);
    end else if (cmd_i.div_load_pct) begin
      // quotient is below 128, so the top bits are already a valid remainder
      rem_d  = num[NUM_W-1:PCT_W];
      quo_d  = {num[PCT_W-1:0], {(MV_W-PCT_W){1'b0}}};
      step_d = STEP_W'(PCT_W);
    end else if (cmd_i.div_step) begin
      rem_d  = ge ? diff[MV_W-1:0] : trial[MV_W-1:0];
      quo_d  = {quo_q[MV_W-2:0], ge};
      step_d = step_q - STEP_W'(1);
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q  <= slot_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      step_q  <= step_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    if (cmd_i.load_sample) begin
      sample_q <= adc_sample_i;
    end
    if (cmd_i.scale) begin
      mv_q <= mv_d;
    end
    if (cmd_i.update) begin
      window_q[slot_q] <= mv_q;
    end
    if (cmd_i.div_load_avg) begin
      den_q <= MV_W'(count_q);
    end else if (cmd_i.div_load_pct) begin
      den_q <= cfg_i.full_mv - cfg_i.empty_mv;
    end
    if (cmd_i.classify) begin
      avg_q     <= quo_q;
      ge_full_q <= (quo_q >= cfg_i.full_mv);
      in_span_q <= (quo_q < cfg_i.full_mv) && (quo_q > cfg_i.empty_mv);
      unsafe_q  <= (quo_q < cfg_i.critical_mv);
    end
    if (cmd_i.emit) begin
      out_avg_q    <= avg_q;
      out_pct_q    <= in_span_q ? quo_q[PCT_W-1:0] : (ge_full_q ? PCT_FULL : '0);
      out_unsafe_q <= unsafe_q;
      out_full_q   <= win_full;
    end
  end

  assign status_o.div_done = (step_q == '0);
  assign status_o.in_span  = in_span_q;
  assign status_o.out_busy = out_valid_q && !out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign average_mv_o     = out_avg_q;
  assign charge_percent_o = out_pct_q;
  assign unsafe_o         = out_unsafe_q;
  assign window_full_o    = out_full_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(WINDOW))
    else $error("fill count past window size");

  a_step_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> step_q != '0)
    else $error("divider stepped after finishing");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> out_valid_q)
    else $error("emit did not raise output valid");

  a_pct_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> out_pct_q <= PCT_FULL)
    else $error("charge percent above 100");

endmodule

// ----- design/bvm_ctrl.sv -----
// Controller state machine of the battery voltage monitor: sequences scale,
// window update, the two divisions and the output load. Depends on bvm_pkg.
module bvm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  bvm_pkg::bvm_status_t status_i,
  output bvm_pkg::bvm_cmd_t    cmd_o
);
  import bvm_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCALE,
    ST_UPDATE,
    ST_AVG_LOAD,
    ST_AVG_DIV,
    ST_CLASSIFY,
    ST_PCT_LOAD,
    ST_PCT_DIV,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load_sample = in_valid_i;
        if (in_valid_i) state_d = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_AVG_LOAD;
      end
      ST_AVG_LOAD: begin
        cmd_o.div_load_avg = 1'b1;
        state_d            = ST_AVG_DIV;
      end
      ST_AVG_DIV: begin
        cmd_o.div_step = !status_i.div_done;
        if (status_i.div_done) state_d = ST_CLASSIFY;
      end
      ST_CLASSIFY: begin
        cmd_o.classify = 1'b1;
        state_d        = ST_PCT_LOAD;
      end
      ST_PCT_LOAD: begin
        // percent division only between empty and full
        cmd_o.div_load_pct = status_i.in_span;
        state_d            = status_i.in_span ? ST_PCT_DIV : ST_EMIT;
      end
      ST_PCT_DIV: begin
        cmd_o.div_step = !status_i.div_done;
        if (status_i.div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = !status_i.out_busy;
        if (!status_i.out_busy) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);

endmodule

// ----- design/battery_voltage_monitor_unit.sv -----
// Top level of the battery voltage monitor: config registers, stream ports,
// controller and datapath. Depends on bvm_pkg, bvm_ctrl and bvm_datapath.
//
// Takes one raw ADC reading per input item, scales it to millivolts as
// (sample * mv_per_count_q8) >> 8 (saturated to 18 bits), keeps it in a
// 16-entry moving window and returns one result item: the floor mean of the
// filled entries, a clamped linear charge percent between empty_mv and
// full_mv, an unsafe flag (mean below critical_mv) and a window-full flag.
// One item is in flight at a time. The time from acceptance of an item until
// the next one can be taken is set mainly by the shared restoring divider,
// which produces one quotient bit per cycle: 18 bits for the mean, then 7
// bits for the percent; the percent division is skipped when the mean lies
// outside the empty..full span. A finished result waits in the output register,
// so the next item is accepted while it is still pending. Config writes are
// always ready and take effect at once; write them only while idle.
module battery_voltage_monitor_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // item input: [9:0] adc_sample
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [bvm_pkg::S_TDATA_W-1:0]       s_axis_tdata,
  // result: [17:0] average_mv, [24:18] charge_percent, [25] unsafe,
  //         [26] window_full
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [bvm_pkg::M_TDATA_W-1:0]       m_axis_tdata,
  // config write channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [bvm_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [bvm_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import bvm_pkg::*;

  bvm_cfg_t    cfg_q;
  bvm_cmd_t    cmd;
  bvm_status_t status;

  logic [MV_W-1:0]  average_mv;
  logic [PCT_W-1:0] charge_percent;
  logic             unsafe;
  logic             window_full;

  assign cfg_ready_o = 1'b1;

  // Config registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mv_per_count_q8 <= RST_MV_PER_COUNT;
      cfg_q.empty_mv        <= RST_EMPTY_MV;
      cfg_q.full_mv         <= RST_FULL_MV;
      cfg_q.critical_mv     <= RST_CRITICAL_MV;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_MV_PER_COUNT: cfg_q.mv_per_count_q8 <= cfg_data_i[SCALE_W-1:0];
        REG_EMPTY_MV:     cfg_q.empty_mv        <= cfg_data_i[MV_W-1:0];
        REG_FULL_MV:      cfg_q.full_mv         <= cfg_data_i[MV_W-1:0];
        REG_CRITICAL_MV:  cfg_q.critical_mv     <= cfg_data_i[MV_W-1:0];
        default: ;
      endcase
    end
  end

  bvm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  bvm_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .cfg_i            (cfg_q),
    .adc_sample_i     (s_axis_tdata[ADC_W-1:0]),
    .out_ready_i      (m_axis_tready),
    .out_valid_o      (m_axis_tvalid),
    .average_mv_o     (average_mv),
    .charge_percent_o (charge_percent),
    .unsafe_o         (unsafe),
    .window_full_o    (window_full)
  );

  assign m_axis_tdata = {{(M_TDATA_W-MV_W-PCT_W-2){1'b0}},
                         window_full, unsafe, charge_percent, average_mv};

endmodule

// ----- sim/tb_battery_voltage_monitor_unit.sv -----
// Self-checking testbench for battery_voltage_monitor_unit: directed table then random phases,
// every result checked against a cycle-free model of the moving-average monitor or a typed reading.
// Depends on bvm_pkg and the design files under design/.
module tb_battery_voltage_monitor_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import bvm_pkg::*;

  localparam int unsigned MAX_GAP     = 17;   // longest idle draw per item, either side
  localparam int unsigned ITEM_TARGET = 500;  // random items
  localparam int unsigned STALL_LIMIT = 2000; // cycles without any handshake
  localparam int unsigned END_WAIT    = 80;   // drain margin
  localparam int unsigned MAX_REPORTS = 10;
  localparam int unsigned MV_CEIL     = 32'(MV_MAX);

  // Indexes past the register list: writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_IDX_HOLE = REG_CRITICAL_MV + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_IDX_TOP  = '1;

  // Same layout as m_axis_tdata, lowest field last
  typedef struct packed {
    logic             window_full;
    logic             unsafe;
    logic [PCT_W-1:0] charge_percent;
    logic [MV_W-1:0]  average_mv;
  } battery_reading_t;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_e;

  typedef struct {
    row_kind_e               kind;
    logic [CFG_IDX_W-1:0]    reg_idx;
    logic [CFG_DATA_W-1:0]   value;   // register data, or the sample in the low bits
    int unsigned             reps;
    bit                      typed;   // use want instead of the model
    battery_reading_t        want;
  } stim_row_t;

  // First sample after reset is zero: mean 0, below critical, window not full
  localparam battery_reading_t FIRST_READING =
    '{window_full: 1'b0, unsafe: 1'b1, charge_percent: '0, average_mv: '0};
  localparam battery_reading_t NO_READING = '0;

  localparam int unsigned DIRECTED_ROWS = 27;

  stim_row_t directed_rows [DIRECTED_ROWS] = '{
    '{ROW_ITEM, '0,               18'd0,       1,  1'b1, FIRST_READING},
    '{ROW_ITEM, '0,               18'd1023,    1,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd1,       1,  1'b0, NO_READING},
    // top scale (upper data bits dropped), widest span, critical at max
    '{ROW_CFG,  REG_MV_PER_COUNT, 18'h3FFFF,   0,  1'b0, NO_READING},
    '{ROW_CFG,  REG_EMPTY_MV,     18'd0,       0,  1'b0, NO_READING},
    '{ROW_CFG,  REG_FULL_MV,      18'h3FFFF,   0,  1'b0, NO_READING},
    '{ROW_CFG,  REG_CRITICAL_MV,  18'h3FFFF,   0,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd1023,    14, 1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd512,     1,  1'b0, NO_READING},
    // writes past the list are ignored
    '{ROW_CFG,  REG_IDX_TOP,      18'h3FFFF,   0,  1'b0, NO_READING},
    '{ROW_CFG,  REG_IDX_HOLE,     18'd0,       0,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd1023,    1,  1'b0, NO_READING},
    // full equal to empty, then full below empty
    '{ROW_CFG,  REG_EMPTY_MV,     18'd40000,   0,  1'b0, NO_READING},
    '{ROW_CFG,  REG_FULL_MV,      18'd40000,   0,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd300,     1,  1'b0, NO_READING},
    '{ROW_CFG,  REG_FULL_MV,      18'd20000,   0,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd100,     1,  1'b0, NO_READING},
    '{ROW_CFG,  REG_CRITICAL_MV,  18'd0,       0,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd0,       1,  1'b0, NO_READING},
    '{ROW_CFG,  REG_MV_PER_COUNT, 18'd0,       0,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd1023,    1,  1'b0, NO_READING},
    // back to reset values
    '{ROW_CFG,  REG_MV_PER_COUNT, CFG_DATA_W'(RST_MV_PER_COUNT), 0, 1'b0, NO_READING},
    '{ROW_CFG,  REG_EMPTY_MV,     RST_EMPTY_MV,     0, 1'b0, NO_READING},
    '{ROW_CFG,  REG_FULL_MV,      RST_FULL_MV,      0, 1'b0, NO_READING},
    '{ROW_CFG,  REG_CRITICAL_MV,  RST_CRITICAL_MV,  0, 1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd700,     1,  1'b0, NO_READING},
    '{ROW_ITEM, '0,               18'd350,     1,  1'b0, NO_READING}
  };

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata;   // [9:0] adc_sample
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_TDATA_W-1:0]  m_axis_tdata;   // [17:0] avg, [24:18] pct, [25] unsafe, [26] full
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  battery_voltage_monitor_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // Model of the monitor: its own registers and window
  bvm_cfg_t          model_cfg = '{RST_MV_PER_COUNT, RST_EMPTY_MV, RST_FULL_MV, RST_CRITICAL_MV};
  logic [MV_W-1:0]   mv_window [WINDOW] = '{default: '0};
  logic [SLOT_W-1:0] next_slot   = '0;
  logic [CNT_W-1:0]  fill_level  = '0;
  logic [SUM_W-1:0]  running_sum = '0;

  battery_reading_t  expected_readings [$];
  int unsigned       mismatch_count = 0;
  int unsigned       idle_cycles = 0;
  bit                quiet_phase = 1'b0;   // no idling on either side

  // Advances the window by one sample and returns the reading it yields
  function automatic battery_reading_t predict_reading(input logic [ADC_W-1:0] raw);
    logic [PROD_W-1:0] product;
    logic [PROD_W-1:0] scaled;
    logic [MV_W-1:0]   mv;
    logic [SUM_W-1:0]  mean_wide;
    logic [MV_W-1:0]   mean;
    logic [NUM_W-1:0]  numer;
    logic [NUM_W-1:0]  span;
    battery_reading_t  r;
    product = PROD_W'(raw[ADC_BITS-1:0]) * PROD_W'(model_cfg.mv_per_count_q8);
    scaled  = product >> FRAC_BITS;
    mv      = (scaled > PROD_W'(MV_MAX)) ? MV_MAX : scaled[MV_W-1:0];

    running_sum = running_sum - SUM_W'(mv_window[next_slot]) + SUM_W'(mv);
    mv_window[next_slot] = mv;
    next_slot = (next_slot == SLOT_W'(WINDOW - 1)) ? '0 : next_slot + 1'b1;
    if (fill_level < CNT_W'(WINDOW)) fill_level = fill_level + 1'b1;

    mean_wide = running_sum / SUM_W'(fill_level);
    mean = (mean_wide > SUM_W'(MV_MAX)) ? MV_MAX : mean_wide[MV_W-1:0];

    r.average_mv = mean;
    // full test first, so a span of zero or below never divides
    if (mean >= model_cfg.full_mv) begin
      r.charge_percent = PCT_FULL;
    end else if (mean <= model_cfg.empty_mv) begin
      r.charge_percent = '0;
    end else begin
      numer = NUM_W'(mean - model_cfg.empty_mv) * NUM_W'(PCT_FULL);
      span  = NUM_W'(model_cfg.full_mv - model_cfg.empty_mv);
      r.charge_percent = PCT_W'(numer / span);
    end
    r.unsafe      = (mean < model_cfg.critical_mv);
    r.window_full = (fill_level == CNT_W'(WINDOW));
    return r;
  endfunction

  // Waits out every pending result, then writes one register
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MV_PER_COUNT: model_cfg.mv_per_count_q8 = value[SCALE_W-1:0];
      REG_EMPTY_MV:     model_cfg.empty_mv        = value[MV_W-1:0];
      REG_FULL_MV:      model_cfg.full_mv         = value[MV_W-1:0];
      REG_CRITICAL_MV:  model_cfg.critical_mv     = value[MV_W-1:0];
      default: ;
    endcase
  endtask

  // Offers one sample after a random gap; queues its reading on acceptance
  task automatic send_sample(input logic [ADC_W-1:0] raw, input bit typed,
                             input battery_reading_t want);
    int unsigned      gap;
    battery_reading_t predicted;
    gap = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
    cfg_valid_i <= 1'b0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(raw);
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = predict_reading(raw);
    expected_readings.push_back(typed ? want : predicted);
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Result side: random stall before each item, sometimes none
  initial begin
    int unsigned stall;
    m_axis_tready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      stall = quiet_phase ? 0 : $urandom_range(0, MAX_GAP);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    battery_reading_t got;
    battery_reading_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = battery_reading_t'(m_axis_tdata[$bits(battery_reading_t)-1:0]);
      if (expected_readings.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result: avg=%0d pct=%0d unsafe=%0b full=%0b",
                   got.average_mv, got.charge_percent, got.unsafe, got.window_full);
      end else begin
        want = expected_readings.pop_front();
        if (got.average_mv != want.average_mv || got.charge_percent != want.charge_percent ||
            got.unsafe != want.unsafe || got.window_full != want.window_full) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"mismatch: exp avg=%0d pct=%0d unsafe=%0b full=%0b, ",
                      "got avg=%0d pct=%0d unsafe=%0b full=%0b"},
                     want.average_mv, want.charge_percent, want.unsafe, want.window_full,
                     got.average_mv, got.charge_percent, got.unsafe, got.window_full);
        end
      end
    end
  end

  // Watchdog: no handshake on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int unsigned           items_sent;
    int unsigned           center;
    int unsigned           spread;
    int unsigned           phase_len;
    int unsigned           scale_eff;
    int unsigned           center_mv;
    int unsigned           lo_mv;
    int unsigned           hi_mv;
    int unsigned           empty_v;
    int unsigned           full_v;
    int unsigned           crit_v;
    int                    sample;
    logic [CFG_DATA_W-1:0] scale_word;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_index_i   <= '0;
    cfg_data_i    <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table
    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        write_register(directed_rows[r].reg_idx, directed_rows[r].value);
      end else begin
        for (int n = 0; n < directed_rows[r].reps; n++)
          send_sample(directed_rows[r].value[ADC_W-1:0], directed_rows[r].typed,
                      directed_rows[r].want);
      end
    end

    // Random phases: new settings, then a run of samples clustered around a level
    items_sent = 0;
    while (items_sent < ITEM_TARGET) begin
      quiet_phase = 1'b0;
      case ($urandom_range(0, 4))
        0:       scale_word = '0;
        1:       scale_word = '1;              // upper bits dropped by the register
        2:       scale_word = CFG_DATA_W'(RST_MV_PER_COUNT);
        default: scale_word = CFG_DATA_W'($urandom());
      endcase
      scale_eff = 32'(scale_word[SCALE_W-1:0]);
      center    = $urandom_range(0, 1023);
      center_mv = (center * scale_eff) >> FRAC_BITS;
      lo_mv     = center_mv - (center_mv < 4000 ? $urandom_range(0, center_mv)
                                                : $urandom_range(0, 4000));
      hi_mv     = center_mv + $urandom_range(0, 4000);
      if (hi_mv > MV_CEIL) hi_mv = MV_CEIL;
      case ($urandom_range(0, 7))
        0: begin empty_v = 0;         full_v = MV_CEIL;   end
        1: begin empty_v = hi_mv;     full_v = lo_mv;     end  // full below empty
        2: begin empty_v = center_mv; full_v = center_mv; end  // zero span
        3: begin empty_v = $urandom_range(0, MV_CEIL); full_v = 0; end
        default: begin empty_v = lo_mv; full_v = hi_mv; end
      endcase
      case ($urandom_range(0, 3))
        0:       crit_v = 0;
        1:       crit_v = MV_CEIL;
        default: crit_v = $urandom_range(lo_mv, hi_mv);
      endcase

      write_register(REG_MV_PER_COUNT, scale_word);
      write_register(REG_EMPTY_MV, CFG_DATA_W'(empty_v));
      write_register(REG_FULL_MV, CFG_DATA_W'(full_v));
      write_register(REG_CRITICAL_MV, CFG_DATA_W'(crit_v));
      if ($urandom_range(0, 2) == 0)
        write_register(CFG_IDX_W'($urandom_range(REG_IDX_HOLE, REG_IDX_TOP)),
                       CFG_DATA_W'($urandom()));

      quiet_phase = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       spread = 0;
        1:       spread = 1023;
        default: spread = $urandom_range(1, 40);
      endcase
      phase_len = $urandom_range(15, 60);
      for (int n = 0; n < phase_len; n++) begin
        sample = int'(center) + int'($urandom_range(0, 2 * spread)) - int'(spread);
        if (sample < 0) sample = 0;
        if (sample > 1023) sample = 1023;
        send_sample(ADC_W'(sample), 1'b0, NO_READING);
        items_sent++;
      end
    end

    s_axis_tvalid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);

    if (mismatch_count == 0 && expected_readings.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/bvm_pkg.sv
design/bvm_datapath.sv
design/bvm_ctrl.sv
design/battery_voltage_monitor_unit.sv
sim/tb_battery_voltage_monitor_unit.sv
